[hw/rtl/ppf_pkg.sv]
// shared types, constants and tables of the point follower
package ppf_pkg;

  localparam int CordicSteps = 16;

  localparam logic [15:0] KpTurnRst  = 16'd26;
  localparam logic [15:0] KiTurnRst  = 16'd0;
  localparam logic [15:0] KdTurnRst  = 16'd26;
  localparam logic [15:0] KpDriveRst = 16'd1024;
  localparam logic [15:0] KiDriveRst = 16'd8;
  localparam logic [15:0] KdDriveRst = 16'd154;

  typedef enum logic [2:0] {
    RegTargetX = 3'd0,
    RegTargetY = 3'd1,
    RegKpTurn  = 3'd2,
    RegKiTurn  = 3'd3,
    RegKdTurn  = 3'd4,
    RegKpDrive = 3'd5,
    RegKiDrive = 3'd6,
    RegKdDrive = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic signed [23:0] current_x;
    logic signed [23:0] current_y;
    logic        [12:0] heading;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] left_speed;
    logic signed [15:0] right_speed;
    logic               arrived;
  } out_item_t;

  // atan(2^-i) in 2^-16 degree
  function automatic logic [21:0] atan_lut(input logic [4:0] idx);
    logic [21:0] v;
    begin
      case (idx)
        5'd0:  v = 22'd2949120;
        5'd1:  v = 22'd1740967;
        5'd2:  v = 22'd919879;
        5'd3:  v = 22'd466945;
        5'd4:  v = 22'd234379;
        5'd5:  v = 22'd117304;
        5'd6:  v = 22'd58666;
        5'd7:  v = 22'd29335;
        5'd8:  v = 22'd14668;
        5'd9:  v = 22'd7334;
        5'd10: v = 22'd3667;
        5'd11: v = 22'd1833;
        5'd12: v = 22'd917;
        5'd13: v = 22'd458;
        5'd14: v = 22'd229;
        5'd15: v = 22'd115;
        5'd16: v = 22'd57;
        5'd17: v = 22'd29;
        5'd18: v = 22'd14;
        5'd19: v = 22'd7;
        5'd20: v = 22'd4;
        5'd21: v = 22'd2;
        5'd22: v = 22'd1;
        default: v = 22'd0;
      endcase
      return v;
    end
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [18:0] v);
    logic signed [15:0] r;
    begin
      if (v > 19'sd32767) begin
        r = 16'sh7fff;
      end else if (v < -19'sd32768) begin
        r = 16'sh8000;
      end else begin
        r = v[15:0];
      end
      return r;
    end
  endfunction

endpackage

[hw/rtl/ppf_if.sv]
// valid/ready channels for pose items and speed results
interface ppf_in_if;
  logic              valid;
  logic              ready;
  ppf_pkg::in_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface ppf_out_if;
  logic               valid;
  logic               ready;
  ppf_pkg::out_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

[hw/rtl/pid_point_follower_core.sv]
// go-to-point pid controller: distance, bearing, two pid terms, wheel speeds
//
//  channel  dir  handshake     payload
//  in_i     in   valid/ready   current_x, current_y, heading
//  out_o    out  valid/ready   left_speed, right_speed, arrived
//  apb      in   psel/penable  target and gain registers at byte address 4*index
//
// a pose runs through the multiplier, the 25-step square root, the cordic loop and at
// most two heading wrap steps before the pid terms; one that arrives stops after the
// distance check, and one that comes while latched goes straight to the result
// reset clears the sums, previous values and the arrived latch and loads default gains
// in_i is ready only while the sequencer is idle; a finished result waits in the
// output register, so a new pose is taken while out_o is stalled
module pid_point_follower_core #(
  parameter int CORDIC_STEPS = ppf_pkg::CordicSteps
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ppf_in_if.sink      in_i,
  ppf_out_if.source   out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_MUL  = 9'b000000010,
    S_CHK  = 9'b000000100,
    S_ROOT = 9'b000001000,
    S_CORD = 9'b000010000,
    S_WRAP = 9'b000100000,
    S_TFIN = 9'b001000000,
    S_DFIN = 9'b010000000,
    S_DONE = 9'b100000000
  } state_e;

  // products summed by the shared multiplier, in issue order
  typedef enum logic [2:0] {
    OP_SQX = 3'd0,
    OP_SQY = 3'd1,
    OP_KPT = 3'd2,
    OP_KIT = 3'd3,
    OP_KDT = 3'd4,
    OP_KPD = 3'd5,
    OP_KID = 3'd6,
    OP_KDD = 3'd7
  } op_e;

  // configuration registers
  logic signed [23:0] tx_q, ty_q;
  logic [15:0] kpt_q, kit_q, kdt_q, kpd_q, kid_q, kdd_q;
  logic        cfg_wr, tgt_wr;
  ppf_pkg::reg_idx_e cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = ppf_pkg::reg_idx_e'(paddr[4:2]);
  assign cfg_wr  = psel & penable & pwrite;
  assign tgt_wr  = cfg_wr &&
                   (cfg_idx == ppf_pkg::RegTargetX || cfg_idx == ppf_pkg::RegTargetY);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_q  <= '0;
      ty_q  <= '0;
      kpt_q <= ppf_pkg::KpTurnRst;
      kit_q <= ppf_pkg::KiTurnRst;
      kdt_q <= ppf_pkg::KdTurnRst;
      kpd_q <= ppf_pkg::KpDriveRst;
      kid_q <= ppf_pkg::KiDriveRst;
      kdd_q <= ppf_pkg::KdDriveRst;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        ppf_pkg::RegTargetX: tx_q  <= pwdata[23:0];
        ppf_pkg::RegTargetY: ty_q  <= pwdata[23:0];
        ppf_pkg::RegKpTurn:  kpt_q <= pwdata[15:0];
        ppf_pkg::RegKiTurn:  kit_q <= pwdata[15:0];
        ppf_pkg::RegKdTurn:  kdt_q <= pwdata[15:0];
        ppf_pkg::RegKpDrive: kpd_q <= pwdata[15:0];
        ppf_pkg::RegKiDrive: kid_q <= pwdata[15:0];
        ppf_pkg::RegKdDrive: kdd_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      ppf_pkg::RegTargetX: prdata = {8'd0, tx_q};
      ppf_pkg::RegTargetY: prdata = {8'd0, ty_q};
      ppf_pkg::RegKpTurn:  prdata = {16'd0, kpt_q};
      ppf_pkg::RegKiTurn:  prdata = {16'd0, kit_q};
      ppf_pkg::RegKdTurn:  prdata = {16'd0, kdt_q};
      ppf_pkg::RegKpDrive: prdata = {16'd0, kpd_q};
      ppf_pkg::RegKiDrive: prdata = {16'd0, kid_q};
      ppf_pkg::RegKdDrive: prdata = {16'd0, kdd_q};
      default:             prdata = '0;
    endcase
  end

  // sequencer and datapath state
  state_e state_q, state_d;
  op_e    op_q, op_d;
  logic   ph_q, ph_d;
  logic [4:0] step_q, step_d;
  logic signed [24:0] dx_q, dx_d, dy_q, dy_d;
  logic [12:0] hd_q, hd_d;
  logic signed [58:0] prod_q, prod_d;
  logic signed [59:0] acc_q, acc_d;
  logic [49:0] rem_q, rem_d, root_q, root_d, bit_q, bit_d;
  logic [24:0] d_q, d_d;
  logic signed [43:0] cx_q, cx_d, cy_q, cy_d;
  logic signed [26:0] cz_q, cz_d;
  logic signed [16:0] err_q, err_d;
  logic signed [13:0] rate_q, rate_d;
  logic signed [25:0] drate_q, drate_d;
  logic signed [31:0] asum_q, asum_d;
  logic [31:0] dsum_q, dsum_d;
  logic signed [12:0] pang_q, pang_d;
  logic [24:0] pdist_q, pdist_d;
  logic        arr_q, arr_d;
  logic signed [17:0] turn_q, turn_d;
  logic signed [15:0] rl_q, rl_d, rr_q, rr_d;
  logic        ra_q, ra_d;
  logic        ovalid_q, ovalid_d;
  ppf_pkg::out_item_t obuf_q, obuf_d;

  // shared multiplier operands
  logic signed [32:0] mul_a;
  logic signed [25:0] mul_b;

  always_comb begin
    case (op_q)
      OP_SQX: begin
        mul_a = {{8{dx_q[24]}}, dx_q};
        mul_b = {dx_q[24], dx_q};
      end
      OP_SQY: begin
        mul_a = {{8{dy_q[24]}}, dy_q};
        mul_b = {dy_q[24], dy_q};
      end
      OP_KPT: begin
        mul_a = {{16{err_q[16]}}, err_q};
        mul_b = {10'd0, kpt_q};
      end
      OP_KIT: begin
        mul_a = {asum_q[31], asum_q};
        mul_b = {10'd0, kit_q};
      end
      OP_KDT: begin
        mul_a = {{19{rate_q[13]}}, rate_q};
        mul_b = {10'd0, kdt_q};
      end
      OP_KPD: begin
        mul_a = {8'd0, d_q};
        mul_b = {10'd0, kpd_q};
      end
      OP_KID: begin
        mul_a = {1'b0, dsum_q};
        mul_b = {10'd0, kid_q};
      end
      default: begin
        mul_a = {{7{drate_q[25]}}, drate_q};
        mul_b = {10'd0, kdd_q};
      end
    endcase
  end

  // helpers
  logic [49:0] trial, root_nxt;
  logic signed [43:0] xs, ys, x0, y0;
  logic signed [26:0] atan_v, cz_nxt, bear_sum;
  logic signed [32:0] asum_ext;
  logic [32:0] dsum_ext;
  logic signed [59:0] tv, dv;
  logic [14:0] drive;
  logic signed [18:0] lsum, rsum;

  assign trial  = root_q + bit_q;
  assign xs     = cx_q >>> step_q;
  assign ys     = cy_q >>> step_q;
  assign atan_v = {5'd0, ppf_pkg::atan_lut(step_q)};
  assign x0     = {{3{dx_q[24]}}, dx_q, 16'd0};
  assign y0     = {{3{dy_q[24]}}, dy_q, 16'd0};
  assign tv     = acc_q >>> 4;
  assign dv     = acc_q >>> 8;

  always_comb begin
    if (rem_q >= trial) begin
      root_nxt = (root_q >> 1) + bit_q;
    end else begin
      root_nxt = root_q >> 1;
    end
    if (cy_q > 44'sd0) begin
      cz_nxt = cz_q + atan_v;
    end else begin
      cz_nxt = cz_q - atan_v;
    end
    bear_sum = cz_nxt + 27'sd2048;
    asum_ext = {asum_q[31], asum_q} + {{16{err_q[16]}}, err_q};
    dsum_ext = {1'b0, dsum_q} + {8'd0, d_q};
    if (dv < 60'sd2560) begin
      drive = 15'd2560;
    end else if (dv > 60'sd15360) begin
      drive = 15'd15360;
    end else begin
      drive = dv[14:0];
    end
    lsum = {turn_q[17], turn_q} + $signed({4'd0, drive});
    rsum = {turn_q[17], turn_q} - $signed({4'd0, drive});
    rsum = -rsum;
  end

  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    ph_d     = ph_q;
    step_d   = step_q;
    dx_d     = dx_q;
    dy_d     = dy_q;
    hd_d     = hd_q;
    prod_d   = prod_q;
    acc_d    = acc_q;
    rem_d    = rem_q;
    root_d   = root_q;
    bit_d    = bit_q;
    d_d      = d_q;
    cx_d     = cx_q;
    cy_d     = cy_q;
    cz_d     = cz_q;
    err_d    = err_q;
    rate_d   = rate_q;
    drate_d  = drate_q;
    asum_d   = asum_q;
    dsum_d   = dsum_q;
    pang_d   = pang_q;
    pdist_d  = pdist_q;
    arr_d    = arr_q;
    turn_d   = turn_q;
    rl_d     = rl_q;
    rr_d     = rr_q;
    ra_d     = ra_q;
    obuf_d   = obuf_q;
    ovalid_d = ovalid_q & ~out_o.ready;

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          if (arr_q) begin
            // latched: inputs ignored
            rl_d    = '0;
            rr_d    = '0;
            ra_d    = 1'b1;
            state_d = S_DONE;
          end else begin
            dx_d    = {tx_q[23], tx_q} - {in_i.data.current_x[23], in_i.data.current_x};
            dy_d    = {ty_q[23], ty_q} - {in_i.data.current_y[23], in_i.data.current_y};
            hd_d    = in_i.data.heading;
            acc_d   = '0;
            op_d    = OP_SQX;
            ph_d    = 1'b0;
            state_d = S_MUL;
          end
        end
      end
      S_MUL: begin
        if (!ph_q) begin
          prod_d = mul_a * mul_b;
          ph_d   = 1'b1;
        end else begin
          acc_d = acc_q + {prod_q[58], prod_q};
          ph_d  = 1'b0;
          op_d  = op_e'(op_q + 3'd1);
          case (op_q)
            OP_SQY:  state_d = S_CHK;
            OP_KDT:  state_d = S_TFIN;
            OP_KDD:  state_d = S_DFIN;
            default: state_d = S_MUL;
          endcase
        end
      end
      S_CHK: begin
        if (acc_q[59:16] == '0) begin
          // within one inch: latch and stop, pid state untouched
          arr_d   = 1'b1;
          rl_d    = '0;
          rr_d    = '0;
          ra_d    = 1'b1;
          state_d = S_DONE;
        end else begin
          rem_d   = acc_q[49:0];
          root_d  = '0;
          bit_d   = 50'd1 << 48;
          state_d = S_ROOT;
        end
      end
      S_ROOT: begin
        if (rem_q >= trial) begin
          rem_d = rem_q - trial;
        end
        root_d = root_nxt;
        bit_d  = bit_q >> 2;
        if (bit_q[0]) begin
          d_d    = root_nxt[24:0];
          step_d = '0;
          // pre-rotate into the right half plane
          if (dx_q[24]) begin
            cx_d = -x0;
            cy_d = -y0;
            cz_d = dy_q[24] ? -27'sd11796480 : 27'sd11796480;
          end else begin
            cx_d = x0;
            cy_d = y0;
            cz_d = '0;
          end
          state_d = S_CORD;
        end
      end
      S_CORD: begin
        if (cy_q > 44'sd0) begin
          cx_d = cx_q + ys;
          cy_d = cy_q - xs;
        end else begin
          cx_d = cx_q - ys;
          cy_d = cy_q + xs;
        end
        cz_d = cz_nxt;
        if (step_q == 5'(CORDIC_STEPS - 1)) begin
          err_d   = {{2{bear_sum[26]}}, bear_sum[26:12]} - {4'd0, hd_q};
          state_d = S_WRAP;
        end else begin
          step_d = step_q + 5'd1;
        end
      end
      S_WRAP: begin
        if (err_q > 17'sd2880) begin
          err_d = err_q - 17'sd5760;
        end else if (err_q < -17'sd2880) begin
          err_d = err_q + 17'sd5760;
        end else begin
          if (asum_ext[32] != asum_ext[31]) begin
            asum_d = asum_ext[32] ? 32'sh80000000 : 32'sh7fffffff;
          end else begin
            asum_d = asum_ext[31:0];
          end
          rate_d  = {err_q[12], err_q[12:0]} - {pang_q[12], pang_q};
          pang_d  = err_q[12:0];
          acc_d   = 60'sd8;
          op_d    = OP_KPT;
          ph_d    = 1'b0;
          state_d = S_MUL;
        end
      end
      S_TFIN: begin
        // clamp beyond any speed the wheels can take
        if (tv > 60'sd65536) begin
          turn_d = 18'sd65536;
        end else if (tv < -60'sd65536) begin
          turn_d = -18'sd65536;
        end else begin
          turn_d = tv[17:0];
        end
        dsum_d  = dsum_ext[32] ? 32'hffffffff : dsum_ext[31:0];
        drate_d = {1'b0, d_q} - {1'b0, pdist_q};
        pdist_d = d_q;
        acc_d   = 60'sd128;
        op_d    = OP_KPD;
        ph_d    = 1'b0;
        state_d = S_MUL;
      end
      S_DFIN: begin
        rl_d    = ppf_pkg::sat16(lsum);
        rr_d    = ppf_pkg::sat16(rsum);
        ra_d    = 1'b0;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!ovalid_q || out_o.ready) begin
          obuf_d.left_speed  = rl_q;
          obuf_d.right_speed = rr_q;
          obuf_d.arrived     = ra_q;
          ovalid_d           = 1'b1;
          state_d            = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // a new target restarts the move
    if (tgt_wr) begin
      asum_d  = '0;
      dsum_d  = '0;
      pang_d  = '0;
      pdist_d = '0;
      arr_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      op_q     <= OP_SQX;
      ph_q     <= 1'b0;
      step_q   <= '0;
      asum_q   <= '0;
      dsum_q   <= '0;
      pang_q   <= '0;
      pdist_q  <= '0;
      arr_q    <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      op_q     <= op_d;
      ph_q     <= ph_d;
      step_q   <= step_d;
      asum_q   <= asum_d;
      dsum_q   <= dsum_d;
      pang_q   <= pang_d;
      pdist_q  <= pdist_d;
      arr_q    <= arr_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dx_q    <= dx_d;
    dy_q    <= dy_d;
    hd_q    <= hd_d;
    prod_q  <= prod_d;
    acc_q   <= acc_d;
    rem_q   <= rem_d;
    root_q  <= root_d;
    bit_q   <= bit_d;
    d_q     <= d_d;
    cx_q    <= cx_d;
    cy_q    <= cy_d;
    cz_q    <= cz_d;
    err_q   <= err_d;
    rate_q  <= rate_d;
    drate_q <= drate_d;
    turn_q  <= turn_d;
    rl_q    <= rl_d;
    rr_q    <= rr_d;
    ra_q    <= ra_d;
    obuf_q  <= obuf_d;
  end

  assign in_i.ready = (state_q == S_IDLE);
  assign out_o.valid = ovalid_q;
  assign out_o.data  = obuf_q;

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("sequencer state not one-hot");

  a_arrived_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && out_o.data.arrived) |->
      (out_o.data.left_speed == 16'sd0 && out_o.data.right_speed == 16'sd0))
    else $error("arrived result with nonzero speed");

  a_latch_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (arr_q && !tgt_wr) |=> arr_q)
    else $error("arrived latch dropped without a target write");

  a_root_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ROOT) |-> (bit_q != '0))
    else $error("square root ran past its last bit");

endmodule

[verif/ppf_tb_pkg.sv]
// shared test constants of the point follower testbench
package ppf_tb_pkg;

  localparam int DriveMin = 2560;
  localparam int DriveMax = 15360;
  localparam int HalfTurn = 2880;
  localparam int FullTurn = 5760;

endpackage

[verif/testbench.sv]
// self-checking testbench of the point follower core: directed and random poses and gains against a predictor
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  ppf_in_if in_ch ();
  ppf_out_if out_ch ();

  pid_point_follower_core uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_ch.sink), .out_o(out_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk_i = ~clk_i;

  // predictor copy of the registers and controller state
  logic signed [23:0] tgt_x, tgt_y;
  logic [15:0] gain [2:7];
  longint ang_sum, prev_ang, dist_sum, prev_dist;
  bit latched;

  ppf_pkg::out_item_t speed_q [$];
  int mismatches = 0;
  bit failed = 0;
  bit rx_hold = 0;
  bit rx_gaps = 1;
  bit tx_gaps = 1;

  function automatic longint floor_shr(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint isqrt(longint s);
    longint r;
    r = longint'($sqrt(real'(s)));
    while (r * r > s) r--;
    while ((r + 1) * (r + 1) <= s) r++;
    return r;
  endfunction

  function automatic longint bearing16(longint dx, longint dy);
    longint x, y, z, xs, ys;
    longint tab [24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                         29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57,
                         29, 14, 7, 4, 2, 1, 0};
    x = dx * 65536;
    y = dy * 65536;
    z = 0;
    if (x < 0) begin
      z = (y >= 0) ? 180 * 65536 : -180 * 65536;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < ppf_pkg::CordicSteps && i < 24; i++) begin
      xs = floor_shr(x, i);
      ys = floor_shr(y, i);
      if (y > 0) begin
        x += ys; y -= xs; z += tab[i];
      end else begin
        x -= ys; y += xs; z -= tab[i];
      end
    end
    return floor_shr(z + 2048, 12);
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic ppf_pkg::out_item_t predict_speeds(ppf_pkg::in_item_t p);
    ppf_pkg::out_item_t o;
    longint dx, dy, s, d, err, rate, turn, drive, drate;
    o = '0;
    if (latched) begin
      o.arrived = 1'b1;
      return o;
    end
    dx = longint'(tgt_x) - longint'(p.current_x);
    dy = longint'(tgt_y) - longint'(p.current_y);
    s = dx * dx + dy * dy;
    if (s < 65536) begin
      latched = 1;
      o.arrived = 1'b1;
      return o;
    end
    d = isqrt(s);
    err = bearing16(dx, dy) - longint'(p.heading);
    while (err > ppf_tb_pkg::HalfTurn) err -= ppf_tb_pkg::FullTurn;
    while (err < -ppf_tb_pkg::HalfTurn) err += ppf_tb_pkg::FullTurn;
    ang_sum = clamp(ang_sum + err, -64'sd2147483648, 64'sd2147483647);
    rate = err - prev_ang;
    prev_ang = err;
    turn = floor_shr(longint'(gain[ppf_pkg::RegKpTurn]) * err
                     + longint'(gain[ppf_pkg::RegKiTurn]) * ang_sum
                     + longint'(gain[ppf_pkg::RegKdTurn]) * rate + 8, 4);
    dist_sum = clamp(dist_sum + d, 0, 64'd4294967295);
    drate = d - prev_dist;
    prev_dist = d & 64'h1FFFFFF;
    drive = floor_shr(longint'(gain[ppf_pkg::RegKpDrive]) * d
                      + longint'(gain[ppf_pkg::RegKiDrive]) * dist_sum
                      + longint'(gain[ppf_pkg::RegKdDrive]) * drate + 128, 8);
    drive = clamp(drive, ppf_tb_pkg::DriveMin, ppf_tb_pkg::DriveMax);
    o.left_speed = 16'(clamp(drive + turn, -32768, 32767));
    o.right_speed = 16'(clamp(drive - turn, -32768, 32767));
    return o;
  endfunction

  // wait until every expected result is back, then let the block settle
  task automatic drain();
    while (speed_q.size() != 0) @(negedge clk_i);
    repeat (80) @(negedge clk_i);
  endtask

  // one apb write: setup then access, mirrored into the predictor
  task automatic write_reg(ppf_pkg::reg_idx_e idx, logic [31:0] value);
    @(negedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 5'(idx) << 2; pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx == ppf_pkg::RegTargetX || idx == ppf_pkg::RegTargetY) begin
      if (idx == ppf_pkg::RegTargetX) tgt_x = value[23:0];
      else tgt_y = value[23:0];
      ang_sum = 0; prev_ang = 0; dist_sum = 0; prev_dist = 0; latched = 0;
    end else begin
      gain[idx] = value[15:0];
    end
  endtask

  // random gap length: mostly short, now and then long
  function automatic int gap_len();
    return ($urandom_range(0, 19) == 0) ? $urandom_range(20, 120) : $urandom_range(0, 3);
  endfunction

  // offer one pose and wait for its transfer
  task automatic send_pose(ppf_pkg::in_item_t p);
    repeat ((tx_gaps ? gap_len() : 0) + 1) @(negedge clk_i);
    in_ch.valid <= 1'b1;
    in_ch.data <= p;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    speed_q.push_back(predict_speeds(p));
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
  endtask

  function automatic ppf_pkg::in_item_t near_pose(int spread);
    ppf_pkg::in_item_t p;
    p.current_x = tgt_x + 24'($signed($urandom_range(0, 2 * spread)) - spread);
    p.current_y = tgt_y + 24'($signed($urandom_range(0, 2 * spread)) - spread);
    p.heading = 13'($urandom_range(0, 5759));
    return p;
  endfunction

  // receiver: random ready, compares each transfer with the oldest prediction
  initial begin
    ppf_pkg::out_item_t want;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ch.ready <= !rx_hold && (!rx_gaps || $urandom_range(0, 3) != 0);
      @(posedge clk_i);
      if (out_ch.valid && out_ch.ready) begin
        if (speed_q.size() == 0) begin
          failed = 1;
          if (mismatches++ < 10) $display("unexpected result %p", out_ch.data);
        end else begin
          want = speed_q.pop_front();
          if (out_ch.data.left_speed !== want.left_speed ||
              out_ch.data.right_speed !== want.right_speed ||
              out_ch.data.arrived !== want.arrived) begin
            failed = 1;
            if (mismatches++ < 10)
              $display("mismatch: expected %0d %0d %0b got %0d %0d %0b",
                       want.left_speed, want.right_speed, want.arrived,
                       out_ch.data.left_speed, out_ch.data.right_speed,
                       out_ch.data.arrived);
          end
        end
      end
    end
  end

  // extremes of the pose fields, wrap of the heading and arrival
  task automatic test_directed();
    ppf_pkg::in_item_t p;
    write_reg(ppf_pkg::RegTargetX, 32'h007FFFFF);
    write_reg(ppf_pkg::RegTargetY, 32'hFF800000);
    p = '{24'sh800000, 24'sh7FFFFF, 13'd0};    send_pose(p);
    p = '{24'sh7FFFFF, 24'sh800000, 13'd5759}; send_pose(p);
    p = '{24'sh000000, 24'sh000000, 13'd8191}; send_pose(p);
    p = '{24'sh123456, 24'shFEDCBA, 13'd5760}; send_pose(p);
    p = '{24'sh800000, 24'sh800000, 13'd2880}; send_pose(p);
    drain();
    write_reg(ppf_pkg::RegTargetX, 32'hFFFFF000);
    write_reg(ppf_pkg::RegTargetY, 32'h00001000);
    p = '{24'shFFF000, 24'sh001000, 13'd100};  send_pose(p);  // at target, arrives
    p = '{24'sh000000, 24'sh000000, 13'd0};    send_pose(p);  // latched, ignored
    drain();
    write_reg(ppf_pkg::RegTargetY, 32'h00001000);
    p = '{24'shFFF100, 24'sh001000, 13'd0};    send_pose(p);  // just at one inch
    p = '{24'shFFF001, 24'sh0010FF, 13'd4000}; send_pose(p);  // just inside
    drain();
  endtask

  // gain extremes with random moves, restarting targets between phases
  task automatic test_random();
    logic [15:0] g;
    for (int ph = 0; ph < 24; ph++) begin
      for (int r = ppf_pkg::RegKpTurn; r <= ppf_pkg::RegKdDrive; r++) begin
        case (ph % 4)
          0: g = 16'hFFFF;
          1: g = 16'h0000;
          default: g = 16'($urandom_range(0, 2048));
        endcase
        write_reg(ppf_pkg::reg_idx_e'(r), {16'($urandom_range(0, 65535)), g});
      end
      write_reg(ppf_pkg::RegTargetX, $urandom());
      write_reg(ppf_pkg::RegTargetY, $urandom());
      for (int k = 0; k < 75; k++) begin
        if ($urandom_range(0, 3) == 0) send_pose('{24'($urandom()), 24'($urandom()),
                                                  13'($urandom())});
        else send_pose(near_pose(k < 60 ? 4000 : 300));
      end
      drain();
    end
    for (int r = ppf_pkg::RegKpTurn; r <= ppf_pkg::RegKdDrive; r++)
      write_reg(ppf_pkg::reg_idx_e'(r), 32'($urandom_range(0, 600)));
  endtask

  // receiver holds off while poses keep coming so the input stalls
  task automatic test_backpressure();
    tx_gaps = 0;
    write_reg(ppf_pkg::RegTargetX, 32'h00100000);
    fork
      begin
        rx_hold = 1;
        repeat (600) @(negedge clk_i);
        rx_hold = 0;
      end
      for (int k = 0; k < 40; k++) send_pose(near_pose(100000));
    join
    rx_gaps = 0;
    for (int k = 0; k < 40; k++) send_pose(near_pose(100000));
    rx_gaps = 1;
    tx_gaps = 1;
    drain();
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    tgt_x = '0; tgt_y = '0;
    gain[ppf_pkg::RegKpTurn] = ppf_pkg::KpTurnRst;
    gain[ppf_pkg::RegKiTurn] = ppf_pkg::KiTurnRst;
    gain[ppf_pkg::RegKdTurn] = ppf_pkg::KdTurnRst;
    gain[ppf_pkg::RegKpDrive] = ppf_pkg::KpDriveRst;
    gain[ppf_pkg::RegKiDrive] = ppf_pkg::KiDriveRst;
    gain[ppf_pkg::RegKdDrive] = ppf_pkg::KdDriveRst;
    ang_sum = 0; prev_ang = 0; dist_sum = 0; prev_dist = 0; latched = 0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random();
    test_backpressure();
    drain();
    if (!failed) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // hard stop well past the slowest correct run
  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

[sim.f]
hw/rtl/ppf_pkg.sv
hw/rtl/ppf_if.sv
hw/rtl/pid_point_follower_core.sv
verif/ppf_tb_pkg.sv
verif/testbench.sv
